@@ hdl/dcf_pkg.sv @@
// Package for the decimating complex FIR: widths, commands, shared types.
// No dependencies.
package dcf_pkg;
  localparam int SampleW = 16;
  localparam int CoefW = 16;
  localparam int SumW = 32;
  localparam int CmdW = 2;
  localparam int IdxW = 6;
  localparam int StepW = 8;
  localparam int TapsW = 7;
  localparam int CfgW = 8;
  localparam int CfgIdxW = 1;
  localparam int DefaultMaxTaps = 64;
  localparam int QueueDepth = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_COEF    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP = 1'b0,
    REG_TAPS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } mac_state_t;
endpackage

@@ hdl/dcf_if.sv @@
// Valid/ready channel interfaces for the decimating complex FIR.
// No dependencies.
interface dcf_in_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic signed [15:0] sample;
  logic [5:0] coef_index;
  logic signed [15:0] coef_real;
  logic signed [15:0] coef_imag;
  modport source (output valid, command, sample, coef_index, coef_real, coef_imag,
                  input ready);
  modport sink (input valid, command, sample, coef_index, coef_real, coef_imag,
                output ready);
endinterface

interface dcf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] real_sum;
  logic signed [31:0] imag_sum;
  modport source (output valid, real_sum, imag_sum, input ready);
  modport sink (input valid, real_sum, imag_sum, output ready);
endinterface

@@ hdl/dcf_front.sv @@
// Front end: accepts items, keeps counters, queues work for the MAC engine.
// Depends on dcf_pkg.
module dcf_front #(
  parameter int MAX_TAPS = dcf_pkg::DefaultMaxTaps,
  parameter int TW = $clog2(MAX_TAPS + 1),
  parameter int AW = $clog2(MAX_TAPS)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [dcf_pkg::CmdW-1:0] command,
  input  logic signed [dcf_pkg::SampleW-1:0] sample,
  input  logic [dcf_pkg::IdxW-1:0] coef_index,
  input  logic signed [dcf_pkg::CoefW-1:0] coef_real,
  input  logic signed [dcf_pkg::CoefW-1:0] coef_imag,
  input  logic [dcf_pkg::StepW-1:0] step_reg,
  input  logic [dcf_pkg::TapsW-1:0] taps_reg,
  output logic q_valid,
  input  logic q_ready,
  output logic q_fire,
  output logic [TW-1:0] q_taps,
  output logic signed [dcf_pkg::SampleW-1:0] q_sample,
  output logic q_is_sample,
  output logic q_is_coef,
  output logic [AW-1:0] q_cidx,
  output logic signed [dcf_pkg::CoefW-1:0] q_cre,
  output logic signed [dcf_pkg::CoefW-1:0] q_cim
);
  import dcf_pkg::*;
  localparam int EW = 1 + 1 + 1 + TW + SampleW + AW + 2 * CoefW;
  localparam int QAW = $clog2(QueueDepth);

  logic [EW-1:0] qmem [QueueDepth];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0] cnt;
  logic [TW-1:0] fill_count, fill_count_next;
  logic [StepW-1:0] step_phase, step_phase_next;
  logic [TW-1:0] taps;
  logic [StepW-1:0] step;
  logic fire, acc, push, pop, cidx_ok;
  logic [EW-1:0] entry;

  always_comb begin
    if (taps_reg == '0) taps = TW'(1);
    else if (int'(taps_reg) > MAX_TAPS) taps = TW'(MAX_TAPS);
    else taps = TW'(taps_reg);
    step = (step_reg == '0) ? StepW'(1) : step_reg;
  end

  assign in_ready = (cnt < (QAW + 1)'(QueueDepth));
  assign acc = in_valid && in_ready;
  assign cidx_ok = ({{TW{1'b0}}, coef_index} < (TW + IdxW)'(MAX_TAPS));

  always_comb begin
    fill_count_next = fill_count;
    step_phase_next = step_phase;
    fire = 1'b0;
    if (fill_count < taps) begin
      fill_count_next = fill_count + TW'(1);
      if (fill_count_next == taps) begin
        step_phase_next = '0;
        fire = 1'b1;
      end
    end else begin
      step_phase_next = step_phase + StepW'(1);
      if (step_phase_next >= step) begin
        step_phase_next = '0;
        fire = 1'b1;
      end
    end
    if ({{TW{1'b0}}, step} > (TW + StepW)'(taps)) fire = 1'b0;
  end

  assign push = acc && (command == CMD_SAMPLE || (command == CMD_COEF && cidx_ok));
  assign pop = q_valid && q_ready;
  assign entry = {command == CMD_SAMPLE, command == CMD_COEF, fire, taps, sample,
                  AW'(coef_index), coef_real, coef_imag};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      step_phase <= '0;
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (acc && command == CMD_SAMPLE) begin
        fill_count <= fill_count_next;
        step_phase <= step_phase_next;
      end else if (acc && command == CMD_RESTART) begin
        fill_count <= '0;
        step_phase <= '0;
      end
      if (push) wp <= (wp == QAW'(QueueDepth - 1)) ? '0 : wp + QAW'(1);
      if (pop) rp <= (rp == QAW'(QueueDepth - 1)) ? '0 : rp + QAW'(1);
      cnt <= cnt + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= entry;
  end

  assign q_valid = (cnt != '0);
  assign {q_is_sample, q_is_coef, q_fire, q_taps, q_sample, q_cidx, q_cre, q_cim} = qmem[rp];
endmodule

@@ hdl/dcf_mac.sv @@
// Back end: sample history, coefficient memories and one shared complex MAC.
// Depends on dcf_pkg.
module dcf_mac #(
  parameter int MAX_TAPS = dcf_pkg::DefaultMaxTaps,
  parameter int TW = $clog2(MAX_TAPS + 1),
  parameter int AW = $clog2(MAX_TAPS)
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic q_fire,
  input  logic [TW-1:0] q_taps,
  input  logic signed [dcf_pkg::SampleW-1:0] q_sample,
  input  logic q_is_sample,
  input  logic q_is_coef,
  input  logic [AW-1:0] q_cidx,
  input  logic signed [dcf_pkg::CoefW-1:0] q_cre,
  input  logic signed [dcf_pkg::CoefW-1:0] q_cim,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [dcf_pkg::SumW-1:0] real_sum,
  output logic signed [dcf_pkg::SumW-1:0] imag_sum
);
  import dcf_pkg::*;

  logic signed [SampleW-1:0] hist_mem [2**AW];
  logic signed [CoefW-1:0] cre_mem [MAX_TAPS];
  logic signed [CoefW-1:0] cim_mem [MAX_TAPS];
  logic [AW-1:0] head;
  logic [TW-1:0] k, taps;
  mac_state_t state, state_next;
  logic signed [SampleW-1:0] s_rd;
  logic signed [CoefW-1:0] cr_rd, ci_rd;
  logic rd_v, pr_v;
  logic signed [SumW-1:0] pr_re, pr_im, acc_re, acc_im;
  logic take, start, issue, done_issue;

  assign take = q_valid && q_ready;
  assign start = take && q_is_sample && q_fire;
  assign issue = (state == ST_MAC);
  assign done_issue = issue && (k == taps - TW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_MAC;
      ST_MAC:   if (done_issue) state_next = ST_DRAIN;
      ST_DRAIN: if (!rd_v && !pr_v) state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      k <= '0;
      rd_v <= 1'b0;
      pr_v <= 1'b0;
    end else begin
      state <= state_next;
      if (take && q_is_sample) head <= head - AW'(1);
      if (start) k <= '0;
      else if (issue) k <= k + TW'(1);
      rd_v <= issue;
      pr_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (start) taps <= q_taps;
    if (take && q_is_sample) hist_mem[head - AW'(1)] <= q_sample;
    if (take && q_is_coef) begin
      cre_mem[q_cidx] <= q_cre;
      cim_mem[q_cidx] <= q_cim;
    end
    s_rd <= hist_mem[head + AW'(k)];
    cr_rd <= cre_mem[AW'(k)];
    ci_rd <= cim_mem[AW'(k)];
    pr_re <= SumW'(s_rd) * SumW'(cr_rd);
    pr_im <= SumW'(s_rd) * SumW'(ci_rd);
    if (start) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (pr_v) begin
      acc_re <= acc_re + pr_re;
      acc_im <= acc_im + pr_im;
    end
  end

  assign real_sum = acc_re;
  assign imag_sum = acc_im;
endmodule

@@ hdl/decimating_complex_fir.sv @@
// Decimating complex FIR top level: configuration registers, front end, MAC engine.
// Depends on dcf_pkg, dcf_if, dcf_front and dcf_mac.
//
// A sample that completes a window is handed to the single shared complex
// multiply-accumulate, one tap per cycle; the history and coefficient memories
// give one read each per cycle. Its result is offered once every tap has been
// issued and the read and product registers have drained, and the MAC takes its
// next item the cycle after the result leaves. Other samples and coefficient
// writes queue in a two-entry buffer ahead of the MAC while it is busy.
module decimating_complex_fir #(
  parameter int MAX_TAPS = dcf_pkg::DefaultMaxTaps
) (
  input logic clk,
  input logic rst,
  dcf_in_if.sink in_ch,
  dcf_out_if.source out_ch,
  input logic cfg_we,
  input logic [dcf_pkg::CfgIdxW-1:0] cfg_index,
  input logic [dcf_pkg::CfgW-1:0] cfg_data
);
  import dcf_pkg::*;
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int AW = $clog2(MAX_TAPS);

  logic [StepW-1:0] step_reg;
  logic [TapsW-1:0] taps_reg;
  logic q_valid, q_ready, q_fire, q_is_sample, q_is_coef;
  logic [TW-1:0] q_taps;
  logic signed [SampleW-1:0] q_sample;
  logic [AW-1:0] q_cidx;
  logic signed [CoefW-1:0] q_cre, q_cim;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= StepW'(1);
      taps_reg <= TapsW'(64);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP: step_reg <= cfg_data;
        REG_TAPS: taps_reg <= cfg_data[TapsW-1:0];
        default: ;
      endcase
    end
  end

  dcf_front #(.MAX_TAPS(MAX_TAPS), .TW(TW), .AW(AW)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .command(in_ch.command), .sample(in_ch.sample), .coef_index(in_ch.coef_index),
    .coef_real(in_ch.coef_real), .coef_imag(in_ch.coef_imag),
    .step_reg, .taps_reg,
    .q_valid, .q_ready, .q_fire, .q_taps, .q_sample, .q_is_sample, .q_is_coef,
    .q_cidx, .q_cre, .q_cim
  );

  dcf_mac #(.MAX_TAPS(MAX_TAPS), .TW(TW), .AW(AW)) u_mac (
    .clk, .rst,
    .q_valid, .q_ready, .q_fire, .q_taps, .q_sample, .q_is_sample, .q_is_coef,
    .q_cidx, .q_cre, .q_cim,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .real_sum(out_ch.real_sum), .imag_sum(out_ch.imag_sum)
  );
endmodule

@@ verif/dcf_checker.sv @@
// Checker for the decimating complex FIR: watches both channels and the register port,
// predicts each filter output and compares it with what the block delivers.
// Depends on dcf_pkg and dcf_if.
`timescale 1ns / 100ps
module dcf_checker (
  input logic clk,
  input logic rst,
  dcf_in_if in_ch,
  dcf_out_if out_ch,
  input logic cfg_we,
  input logic [dcf_pkg::CfgIdxW-1:0] cfg_index,
  input logic [dcf_pkg::CfgW-1:0] cfg_data,
  output int fail_count,
  output int pending
);
  import dcf_pkg::*;

  localparam int MaxTaps = DefaultMaxTaps;

  typedef struct {
    int re;
    int im;
  } cplx_sum_t;

  cplx_sum_t expected_sums[$];

  logic [StepW-1:0] step_reg;
  logic [TapsW-1:0] taps_reg;
  logic signed [SampleW-1:0] history[MaxTaps];
  logic signed [CoefW-1:0] coef_re[MaxTaps];
  logic signed [CoefW-1:0] coef_im[MaxTaps];
  int fill;
  int phase;

  assign pending = expected_sums.size();

  function automatic int taps_in_use();
    if (taps_reg == 0) return 1;
    if (taps_reg > MaxTaps) return MaxTaps;
    return int'(taps_reg);
  endfunction

  task automatic absorb_item();
    int taps;
    int step;
    bit fire;
    cplx_sum_t acc;
    fire = 0;
    case (cmd_t'(in_ch.command))
      CMD_COEF: begin
        coef_re[in_ch.coef_index] = in_ch.coef_real;
        coef_im[in_ch.coef_index] = in_ch.coef_imag;
      end
      CMD_RESTART: begin
        fill = 0;
        phase = 0;
      end
      CMD_SAMPLE: begin
        for (int k = MaxTaps - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = in_ch.sample;
        taps = taps_in_use();
        step = (step_reg == 0) ? 1 : int'(step_reg);
        if (fill < taps) begin
          fill++;
          if (fill == taps) begin
            phase = 0;
            fire = 1;
          end
        end else begin
          phase++;
          if (phase >= step) begin
            phase = 0;
            fire = 1;
          end
        end
        if (fire && step <= taps) begin
          acc.re = 0;
          acc.im = 0;
          for (int k = 0; k < taps; k++) begin
            acc.re += int'(history[k]) * int'(coef_re[k]);
            acc.im += int'(history[k]) * int'(coef_im[k]);
          end
          expected_sums.push_back(acc);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cplx_sum_t want;
    if (rst) begin
      step_reg <= 8'd1;
      taps_reg <= 7'd64;
      fill = 0;
      phase = 0;
      fail_count <= 0;
      expected_sums.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected output re=%0d im=%0d", $time,
                   out_ch.real_sum, out_ch.imag_sum);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_sums.pop_front();
          if (want.re != int'(out_ch.real_sum) || want.im != int'(out_ch.imag_sum)) begin
            $display("%0t: expected re=%0d im=%0d, got re=%0d im=%0d", $time,
                     want.re, want.im, out_ch.real_sum, out_ch.imag_sum);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) absorb_item();
      if (cfg_we) begin
        if (reg_idx_t'(cfg_index) == REG_STEP) step_reg <= cfg_data[StepW-1:0];
        else taps_reg <= cfg_data[TapsW-1:0];
      end
    end
  end
endmodule

@@ verif/decimating_complex_fir_tb.sv @@
// Testbench top for the decimating complex FIR: clock, reset, item and register stimulus,
// receiver back-pressure, watchdog and verdict. Depends on all hdl files and dcf_checker.
`timescale 1ns / 100ps
module decimating_complex_fir_tb;
  import dcf_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = REG_STEP;
  logic [CfgW-1:0] cfg_data = 0;
  int fail_count;
  int pending;
  int send_pct = 15;
  int recv_pct = 65;
  int hold_req = 0;
  int hold_left = 0;
  int quiet = 0;

  dcf_in_if in_ch();
  dcf_out_if out_ch();

  decimating_complex_fir dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dcf_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.command = CMD_SAMPLE;
    in_ch.sample = 0;
    in_ch.coef_index = 0;
    in_ch.coef_real = 0;
    in_ch.coef_imag = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk) begin
    if (hold_req > 0 && hold_left == 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("decimating_complex_fir: mismatch");
      $finish;
    end
  end

  task automatic send_item(cmd_t cmd, logic [15:0] smp, logic [5:0] idx,
                           logic [15:0] cre, logic [15:0] cim);
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.sample <= smp;
    in_ch.coef_index <= idx;
    in_ch.coef_real <= cre;
    in_ch.coef_imag <= cim;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    cmd_t cmd;
    r = $urandom_range(99);
    if (r < 82) cmd = CMD_SAMPLE;
    else if (r < 92) cmd = CMD_COEF;
    else if (r < 96) cmd = CMD_RESTART;
    else cmd = CMD_NONE;
    send_item(cmd, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  logic [7:0] steps[10] = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd2, 8'd7, 8'd1, 8'd64, 8'd4, 8'd1};
  logic [7:0] tapsv[10] = '{8'd64, 8'd0, 8'd1, 8'd127, 8'd5, 8'd200, 8'd1, 8'd64, 8'd8, 8'd65};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    for (int i = 0; i < 64; i++) begin
      case (i % 4)
        0: send_item(CMD_COEF, 0, 6'(i), 16'h7fff, 16'h8000);
        1: send_item(CMD_COEF, 0, 6'(i), 16'h8000, 16'h7fff);
        default: send_item(CMD_COEF, 0, 6'(i), 16'($urandom), 16'($urandom));
      endcase
    end
    settle();
    write_reg(REG_TAPS, 8'd4);
    send_item(CMD_SAMPLE, 16'h7fff, 0, 0, 0);
    send_item(CMD_SAMPLE, 16'h8000, 0, 0, 0);
    send_item(CMD_SAMPLE, 16'hffff, 0, 0, 0);
    send_item(CMD_SAMPLE, 16'h0000, 0, 0, 0);
    send_item(CMD_SAMPLE, 16'h8000, 0, 0, 0);
    send_item(CMD_NONE, 16'h1234, 6'h3f, 16'h5555, 16'haaaa);
    send_item(CMD_COEF, 0, 6'd0, 16'h8000, 16'h8000);
    send_item(CMD_SAMPLE, 16'h8000, 0, 0, 0);
    send_item(CMD_RESTART, 0, 0, 0, 0);
    repeat (5) send_item(CMD_SAMPLE, 16'($urandom), 0, 0, 0);
    settle();
    write_reg(REG_TAPS, 8'd2);
    send_item(CMD_SAMPLE, 16'h7fff, 0, 0, 0);
    send_item(CMD_SAMPLE, 16'h7fff, 0, 0, 0);
    settle();
    for (int p = 0; p < 10; p++) begin
      if (p == 3) begin
        send_pct = 65;
        recv_pct = 15;
      end else if (p == 6) begin
        send_pct = 0;
        recv_pct = 0;
      end
      write_reg(REG_STEP, steps[p]);
      write_reg(REG_TAPS, tapsv[p]);
      if (p == 4 || p == 8) hold_req = 500;
      for (int n = 0; n < 130; n++) begin
        if (n == 65 && p % 3 == 1) begin
          in_ch.valid <= 0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        random_item();
      end
      settle();
    end
    if (fail_count == 0) $display("decimating_complex_fir: match");
    else $display("decimating_complex_fir: mismatch");
    $finish;
  end
endmodule
